// File: sv/cfd_pkg.sv
// Shared types, constants and the CRC-16/XMODEM byte update for the frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

	localparam logic [7:0]  HDR_BYTE    = 8'hAA;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam int          MAX_LEN_DEF = 256;
	localparam int          RES_DEPTH   = 4;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_CRC_GOOD = 2'd1,
		KIND_CRC_BAD  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  msg_id;
		logic [7:0]  data;
		logic [9:0]  byte_index;
		logic [9:0]  payload_count;
		logic        last;
	} res_t;

	// MSB-first CRC update over one byte, no reflection
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: sv/cfd_parser.sv
// Front end: frame parser, running CRC and result classification.
`timescale 1ns / 1ps
`default_nettype none

module cfd_parser
	import cfd_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_fire,
	input  wire logic [7:0] rx_byte,
	output logic            res_valid,
	output res_t            res
);

	localparam logic [9:0] MaxLenW = 10'(MAX_LEN);

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_FLAGS_L = 3'd1,
		PH_FLAGS_H = 3'd2,
		PH_MSG_ID  = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CRC_L   = 3'd5,
		PH_CRC_H   = 3'd6
	} phase_t;

	phase_t      phase_q;
	logic [15:0] crc_q;
	logic [7:0]  flags_lo_q;
	logic [9:0]  len_q;
	logic [7:0]  msg_id_q;
	logic [9:0]  rcvd_q;
	logic [7:0]  crc_lo_q;

	logic [15:0] crc_upd;
	logic [15:0] crc_hdr;
	logic [9:0]  len_new;
	logic [9:0]  rcvd_inc;
	logic        pay_done;
	logic [15:0] rx_crc;

	assign crc_upd  = crc_step(crc_q, rx_byte);
	assign crc_hdr  = crc_step(16'h0000, rx_byte);
	assign len_new  = {rx_byte, flags_lo_q[7:6]};
	assign rcvd_inc = rcvd_q + 10'd1;
	assign pay_done = ({1'b0, rcvd_inc} + 11'd1) >= {1'b0, len_q};
	assign rx_crc   = {rx_byte, crc_lo_q};

	always_comb begin
		res_valid         = 1'b0;
		res.kind          = KIND_PAYLOAD;
		res.msg_id        = msg_id_q;
		res.data          = 8'h00;
		res.byte_index    = 10'd0;
		res.payload_count = 10'd0;
		res.last          = 1'b0;
		if (in_fire && phase_q == PH_PAYLOAD) begin
			res_valid      = 1'b1;
			res.data       = rx_byte;
			res.byte_index = rcvd_q;
		end else if (in_fire && phase_q == PH_CRC_H) begin
			res_valid         = 1'b1;
			res.kind          = (rx_crc == crc_q) ? KIND_CRC_GOOD : KIND_CRC_BAD;
			res.payload_count = rcvd_q;
			res.last          = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			crc_q      <= 16'h0000;
			flags_lo_q <= 8'h00;
			len_q      <= 10'd0;
			msg_id_q   <= 8'h00;
			rcvd_q     <= 10'd0;
			crc_lo_q   <= 8'h00;
		end else if (in_fire) begin
			unique case (phase_q)
				PH_FLAGS_L: begin
					flags_lo_q <= rx_byte;
					crc_q      <= crc_upd;
					phase_q    <= PH_FLAGS_H;
				end
				PH_FLAGS_H: begin
					crc_q <= crc_upd;
					len_q <= len_new;
					// zero length or over the limit: drop the frame silently
					if (len_new == 10'd0 || len_new > MaxLenW) begin
						phase_q <= PH_HEADER;
					end else begin
						phase_q <= PH_MSG_ID;
					end
				end
				PH_MSG_ID: begin
					msg_id_q <= rx_byte;
					crc_q    <= crc_upd;
					rcvd_q   <= 10'd0;
					phase_q  <= (len_q > 10'd1) ? PH_PAYLOAD : PH_CRC_L;
				end
				PH_PAYLOAD: begin
					crc_q  <= crc_upd;
					rcvd_q <= rcvd_inc;
					if (pay_done) begin
						phase_q <= PH_CRC_L;
					end
				end
				PH_CRC_L: begin
					crc_lo_q <= rx_byte;
					phase_q  <= PH_CRC_H;
				end
				PH_CRC_H: begin
					phase_q <= PH_HEADER;
				end
				default: begin
					if (rx_byte == HDR_BYTE) begin
						crc_q   <= crc_hdr;
						phase_q <= PH_FLAGS_L;
					end else begin
						phase_q <= PH_HEADER;
					end
				end
			endcase
		end
	end

	a_res_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> in_fire)
		else $error("result produced without an accepted byte");

	a_verdict_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.last) |=> (phase_q == PH_HEADER))
		else $error("parser did not return to header search after verdict");

	a_payload_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.last) |-> (res.kind == KIND_PAYLOAD && res.payload_count == 10'd0))
		else $error("payload result carries verdict fields");

	a_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (({1'b0, rcvd_q} + 11'd1) < {1'b0, len_q}))
		else $error("payload index ran past frame length");

endmodule

`default_nettype wire

// File: sv/cfd_res_fifo.sv
// Back end: result queue between the parser and the result port.
`timescale 1ns / 1ps
`default_nettype none

module cfd_res_fifo
	import cfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire res_t wr_data,
	input  wire logic rd_en,
	output res_t      rd_data,
	output logic      full,
	output logic      empty
);

	localparam int PtrW = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
	localparam int CntW = $clog2(RES_DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(RES_DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(RES_DEPTH);

	res_t            mem_q [RES_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (count_q == CntFull);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntFull)
		else $error("result queue count out of range");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("result written into a full queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + CntW'(1)))
		else $error("queue count did not follow a write");

endmodule

`default_nettype wire

// File: sv/crc16_frame_deframer_core.sv
// Top level of the CRC-16 frame deframer: parser front end and result queue.
// Takes one received byte per cycle (push while full is low) and deframes packets of the form
// 0xAA, little-endian flags word (bits 15..6 = length of message id plus payload), message id,
// payload, little-endian CRC-16/XMODEM over header through payload. Each payload byte comes out
// as its own result tagged with message id and index; after the second CRC byte a verdict result
// (kind 1 good, 2 bad, last set) carries the payload count. Frames with length zero or above
// MAX_LEN are dropped without a result, and a 0xAA inside a frame is frame content. For each
// byte the CRC update and the phase change run in a single parser step, and any result it makes
// is registered in the queue and handed out in order. The result queue is RES_DEPTH deep;
// full rises only when it holds that many untaken results, so input keeps flowing while the
// consumer stalls for up to that many results. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module crc16_frame_deframer_core
	import cfd_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] rx_byte,
	output logic            empty,
	input  wire logic       pop,
	output logic [1:0]      kind,
	output logic [7:0]      msg_id,
	output logic [7:0]      data,
	output logic [9:0]      byte_index,
	output logic [9:0]      payload_count,
	output logic            last
);

	logic in_fire;
	logic res_valid;
	res_t res;
	res_t head;

	assign in_fire = push && !full;

	cfd_parser #(
		.MAX_LEN (MAX_LEN)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.rx_byte   (rx_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	cfd_res_fifo u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.rd_en   (pop),
		.rd_data (head),
		.full    (full),
		.empty   (empty)
	);

	assign kind          = head.kind;
	assign msg_id        = head.msg_id;
	assign data          = head.data;
	assign byte_index    = head.byte_index;
	assign payload_count = head.payload_count;
	assign last          = head.last;

endmodule

`default_nettype wire
